@@ rtl/ple_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ple_pkg: shared types for the positional list engine
// Request, result and cell broadcast structs, plus the operation codes.
// ============================================================================
package ple_pkg;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_GET    = 3'd2,
		OP_LOCATE = 3'd3,
		OP_CLEAR  = 3'd4
	} op_e;

	// One request transaction.
	typedef struct packed {
		logic [2:0]         func;
		logic [6:0]         position;
		logic signed [31:0] value;
	} req_t;

	// One result transaction.
	typedef struct packed {
		logic               status;
		logic signed [31:0] data_out;
		logic [6:0]         found_position;
		logic [6:0]         length;
		logic               empty_res;
	} res_t;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic        go;    // a request is accepted this cycle
		logic        ins;   // legal insert, cells shift toward the tail
		logic        del;   // legal delete, cells shift toward the head
		logic        rd;    // delete or get: select the cell at position
		logic        loc;   // locate: flag cells that match value
		logic [6:0]  pos;
		logic [31:0] value;
	} ctrl_t;

endpackage

@@ rtl/ple_cell.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ple_cell: one list slot
// Holds one entry, shifts with its neighbors on insert and delete, and
// captures a selection leaf (hit flag and entry) for the reduction tree.
// ============================================================================
module ple_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic               clk,
	input  ple_pkg::ctrl_t     ctrl,
	input  logic [CW-1:0]      count,
	input  logic [31:0]        left_in,
	input  logic [31:0]        right_in,
	output logic [31:0]        entry,
	output logic               leaf_hit,
	output logic [31:0]        leaf_data
);
	import ple_pkg::*;

	localparam int EW = CW + 8;
	localparam logic [EW-1:0] MY_POS = EW'(IDX + 1);

	logic [31:0]   entry_q;
	logic          hit_s1;
	logic [31:0]   data_s1;
	logic [EW-1:0] pos_e;
	logic [EW-1:0] cnt_e;
	logic          hit;

	assign pos_e = EW'(ctrl.pos);
	assign cnt_e = EW'(count);
	assign hit   = (ctrl.rd && (MY_POS == pos_e)) ||
	               (ctrl.loc && (MY_POS <= cnt_e) && (entry_q == ctrl.value));

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_POS == pos_e) begin
				entry_q <= ctrl.value;
			end else if (MY_POS > pos_e) begin
				entry_q <= left_in;
			end
		end else if (ctrl.del && (MY_POS >= pos_e)) begin
			entry_q <= right_in;
		end
		// The leaf sees the entry as it was before any shift.
		if (ctrl.go) begin
			hit_s1  <= hit;
			data_s1 <= entry_q;
		end
	end

	assign entry     = entry_q;
	assign leaf_hit  = hit_s1;
	assign leaf_data = data_s1;

endmodule

@@ rtl/ple_tree.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ple_tree: registered first-hit selection tree
// Picks the lowest-indexed leaf whose hit flag is set, with its data and
// index, through one register level per tree level.
// ============================================================================
module ple_tree #(
	parameter int DEPTH = 64,
	parameter int LG    = 6
) (
	input  logic           clk,
	input  logic           leaf_hit  [DEPTH],
	input  logic [31:0]    leaf_data [DEPTH],
	output logic           root_hit,
	output logic [31:0]    root_data,
	output logic [LG-1:0]  root_idx
);
	import ple_pkg::*;

	localparam int P = 1 << LG;

	logic          lf_hit  [P];
	logic [31:0]   lf_data [P];
	logic          nd_hit_q  [P-1];
	logic [31:0]   nd_data_q [P-1];
	logic [LG-1:0] nd_idx_q  [P-1];

	for (genvar i = 0; i < P; i++) begin : g_leaf
		if (i < DEPTH) begin : g_used
			assign lf_hit[i]  = leaf_hit[i];
			assign lf_data[i] = leaf_data[i];
		end else begin : g_pad
			assign lf_hit[i]  = 1'b0;
			assign lf_data[i] = '0;
		end
	end

	// Heap layout: node n has children 2n+1 and 2n+2; indexes from P-1 up
	// are leaves.
	for (genvar n = 0; n < P - 1; n++) begin : g_node
		localparam int L = 2 * n + 1;
		localparam int R = 2 * n + 2;
		if (L >= P - 1) begin : g_bottom
			always_ff @(posedge clk) begin
				if (lf_hit[L - (P - 1)]) begin
					nd_hit_q[n]  <= 1'b1;
					nd_data_q[n] <= lf_data[L - (P - 1)];
					nd_idx_q[n]  <= LG'(L - (P - 1));
				end else begin
					nd_hit_q[n]  <= lf_hit[R - (P - 1)];
					nd_data_q[n] <= lf_data[R - (P - 1)];
					nd_idx_q[n]  <= LG'(R - (P - 1));
				end
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				if (nd_hit_q[L]) begin
					nd_hit_q[n]  <= 1'b1;
					nd_data_q[n] <= nd_data_q[L];
					nd_idx_q[n]  <= nd_idx_q[L];
				end else begin
					nd_hit_q[n]  <= nd_hit_q[R];
					nd_data_q[n] <= nd_data_q[R];
					nd_idx_q[n]  <= nd_idx_q[R];
				end
			end
		end
	end

	assign root_hit  = nd_hit_q[0];
	assign root_data = nd_data_q[0];
	assign root_idx  = nd_idx_q[0];

endmodule

@@ rtl/positional_list_engine_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// positional_list_engine_unit: ordered list with insert/delete by position
// A chain of list cells plus a registered selection tree that returns the
// entry read by get or delete and the first match of locate.
// ============================================================================
// A request transaction is taken when start is high and busy is low. Each
// request yields exactly one result transaction, shown on res for a single
// cycle with res_valid high; the receiver cannot stall it, so it must take
// the result in that cycle. A request passes through the cell leaf
// capture, each level of the registered selection tree in turn, and the
// result register. busy drops in the cycle in which the result is shown,
// so the next request may be started then.
// Insert and delete shift the cells at and beyond position in the accept
// cycle; the list length and the status are settled at that same edge.
module positional_list_engine_unit #(
	parameter int DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ple_pkg::req_t   req,
	output logic            busy,
	output logic            res_valid,
	output ple_pkg::res_t   res
);
	import ple_pkg::*;

	// Count width, comparison width and tree size all follow from DEPTH.
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = CW + 8;
	localparam int LG = $clog2(DEPTH);
	localparam int SW = $clog2(LG + 1);
	localparam logic [SW-1:0] LAST    = SW'(LG);
	localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

	logic          accept;
	logic          busy_q;
	logic [SW-1:0] cnt_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          ok;
	op_e           op;
	op_e           op_q;
	logic          err_q;
	logic          res_valid_q;
	res_t          res_q;
	ctrl_t         ctrl;
	logic [EW-1:0] pos_e;
	logic [EW-1:0] cnt_e;

	logic [31:0]   entry     [DEPTH];
	logic          leaf_hit  [DEPTH];
	logic [31:0]   leaf_data [DEPTH];
	logic          root_hit;
	logic [31:0]   root_data;
	logic [LG-1:0] root_idx;
	logic [LG:0]   found_pos;
	logic          done;

	assign accept = start && !busy_q;
	assign op     = op_e'(req.func);
	assign pos_e  = EW'(req.position);
	assign cnt_e  = EW'(count_q);

	// Legality check and the length after the operation.
	always_comb begin
		ok      = 1'b0;
		count_d = count_q;
		case (op)
			OP_INSERT: begin
				ok = (pos_e != '0) && (pos_e <= cnt_e + EW'(1)) && (cnt_e < DEPTH_E);
				if (ok) begin
					count_d = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				ok = (pos_e != '0) && (pos_e <= cnt_e);
				if (ok) begin
					count_d = count_q - CW'(1);
				end
			end
			OP_GET: begin
				ok = (pos_e != '0) && (pos_e <= cnt_e);
			end
			OP_LOCATE: begin
				ok = 1'b1;
			end
			OP_CLEAR: begin
				ok      = 1'b1;
				count_d = '0;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Broadcast to the cells. Shifts only happen for legal requests.
	always_comb begin
		ctrl.go    = accept;
		ctrl.ins   = accept && ok && (op == OP_INSERT);
		ctrl.del   = accept && ok && (op == OP_DELETE);
		ctrl.rd    = req.func inside {OP_DELETE, OP_GET};
		ctrl.loc   = (op == OP_LOCATE);
		ctrl.pos   = req.position;
		ctrl.value = req.value;
	end

	// The chain: each cell takes its left neighbor on insert and its right
	// neighbor on delete. Nothing ever shifts into the head from the left,
	// and the tail takes zero on delete since it falls beyond the length.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [31:0] left_in;
		logic [31:0] right_in;
		if (i == 0) begin : g_head
			assign left_in = '0;
		end else begin : g_left
			assign left_in = entry[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_in = '0;
		end else begin : g_right
			assign right_in = entry[i+1];
		end
		ple_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.left_in   (left_in),
			.right_in  (right_in),
			.entry     (entry[i]),
			.leaf_hit  (leaf_hit[i]),
			.leaf_data (leaf_data[i])
		);
	end

	ple_tree #(
		.DEPTH (DEPTH),
		.LG    (LG)
	) u_tree (
		.clk       (clk),
		.leaf_hit  (leaf_hit),
		.leaf_data (leaf_data),
		.root_hit  (root_hit),
		.root_data (root_data),
		.root_idx  (root_idx)
	);

	// The tree root is settled once the level count reaches LAST.
	assign done      = busy_q && (cnt_q == LAST);
	assign found_pos = {1'b0, root_idx} + (LG + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= done;
			if (accept) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				count_q <= count_d;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + SW'(1);
			end
		end
	end

	// Per-transaction payload held while the tree works.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			err_q <= !ok;
		end
		if (done) begin
			res_q.status   <= err_q;
			res_q.data_out <= (!err_q && ((op_q == OP_DELETE) || (op_q == OP_GET)))
			                  ? root_data : '0;
			res_q.found_position <= ((op_q == OP_LOCATE) && root_hit)
			                        ? 7'(found_pos) : 7'd0;
			res_q.length    <= 7'(count_q);
			res_q.empty_res <= (count_q == '0);
		end
	end

	assign busy      = busy_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The result is shown only after the request has left the tree.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!busy && $past(busy)))
		else $error("result shown while a request is still in flight");

	// An accepted request always occupies the block on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && (cnt_q == '0))
		else $error("accepted request did not start the tree count");

	// The list never grows past its storage.
	assert property (@(posedge clk) disable iff (!arst_n)
		EW'(count_q) <= DEPTH_E)
		else $error("list length exceeds DEPTH");

	// The length only changes at an accept edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(accept) && $past(arst_n) |-> $stable(count_q))
		else $error("list length changed without a request");

endmodule
